// File: hw/rtl/swd_dp_mem_ap_transfer_core_defines.svh
// assertion helpers for the swd dp / mem-ap transfer core
// each macro expects clk and rst to exist in the module that uses it
`ifndef SWD_DP_MEM_AP_TRANSFER_CORE_DEFINES_SVH
`define SWD_DP_MEM_AP_TRANSFER_CORE_DEFINES_SVH

// same-cycle implication
`define SWDAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWDAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/swdap_pkg.sv
`timescale 1ns / 1ps

package swdap_pkg;

  // reset and mask constants
  localparam logic [31:0] ID_CODE_RESET  = 32'h6BA0_2477;
  localparam logic [31:0] CTRL_KEEP_MASK = 32'hF000_0030;
  localparam logic [31:0] CSW_RESET      = 32'h0000_0002;

  // action codes
  localparam logic ACTION_XFER    = 1'b0;
  localparam logic ACTION_CONNECT = 1'b1;

  // dp register select codes
  localparam logic [1:0] DP_IDR      = 2'd0;
  localparam logic [1:0] DP_CTRL     = 2'd1;
  localparam logic [1:0] DP_BANK_SEL = 2'd2;
  localparam logic [1:0] DP_READ_BUF = 2'd3;

  // ap register select codes (bank 0)
  localparam logic [1:0] AP_CSW = 2'd0;
  localparam logic [1:0] AP_TAR = 2'd1;
  localparam logic [1:0] AP_DRW = 2'd3;

  // csw address increment mode: single
  localparam logic [1:0] INC_SINGLE = 2'd1;

  // access sizes in bytes
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  typedef struct packed {
    logic        action;
    logic        first_of_packet;
    logic        is_read;
    logic        is_ap;
    logic [1:0]  reg_sel;
    logic        match_enable;
    logic        mask_enable;
    logic [31:0] write_data;
    logic [31:0] match_value;
    logic [31:0] compare_mask;
    logic [31:0] bus_read_data;
    logic        bus_error;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        has_read_data;
    logic        ack_fault;
    logic        value_mismatch;
    logic        skipped;
    logic        bus_valid;
    logic        bus_write;
    logic [31:0] bus_address;
    logic [2:0]  bus_size;
    logic [31:0] bus_write_data;
  } result_t;

  // csw size field to byte count
  function automatic logic [2:0] size_bytes(input logic [1:0] csw_size);
    logic [2:0] sz;
    case (csw_size)
      2'd0:    sz = SIZE_BYTE;
      2'd1:    sz = SIZE_HALF;
      default: sz = SIZE_WORD;
    endcase
    return sz;
  endfunction

  // byte lanes kept for a given size
  function automatic logic [31:0] size_mask(input logic [2:0] sz);
    logic [31:0] m;
    case (sz)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/swdap_if.sv
`timescale 1ns / 1ps

// transfer request channel
interface swdap_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        first_of_packet;
  logic        is_read;
  logic        is_ap;
  logic [1:0]  reg_sel;
  logic        match_enable;
  logic        mask_enable;
  logic [31:0] write_data;
  logic [31:0] match_value;
  logic [31:0] compare_mask;
  logic [31:0] bus_read_data;
  logic        bus_error;

  modport source (
    output valid, action, first_of_packet, is_read, is_ap, reg_sel, match_enable,
           mask_enable, write_data, match_value, compare_mask, bus_read_data, bus_error,
    input  ready
  );
  modport sink (
    input  valid, action, first_of_packet, is_read, is_ap, reg_sel, match_enable,
           mask_enable, write_data, match_value, compare_mask, bus_read_data, bus_error,
    output ready
  );
endinterface

// transfer result channel
interface swdap_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        has_read_data;
  logic        ack_fault;
  logic        value_mismatch;
  logic        skipped;
  logic        bus_valid;
  logic        bus_write;
  logic [31:0] bus_address;
  logic [2:0]  bus_size;
  logic [31:0] bus_write_data;

  modport source (
    output valid, read_data, has_read_data, ack_fault, value_mismatch, skipped,
           bus_valid, bus_write, bus_address, bus_size, bus_write_data,
    input  ready
  );
  modport sink (
    input  valid, read_data, has_read_data, ack_fault, value_mismatch, skipped,
           bus_valid, bus_write, bus_address, bus_size, bus_write_data,
    output ready
  );
endinterface

// id code write channel
interface swdap_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/swdap_in_stage.sv
`timescale 1ns / 1ps

module swdap_in_stage
  import swdap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  swdap_in_if.sink     req,
  input  logic         advance,
  output logic         valid,
  output item_t        item
);

  logic full;

  // take a new beat when empty or when the held one moves on
  assign req.ready = !full || advance;
  assign valid     = full;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req.ready) begin
      full <= req.valid;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.action          <= req.action;
      item.first_of_packet <= req.first_of_packet;
      item.is_read         <= req.is_read;
      item.is_ap           <= req.is_ap;
      item.reg_sel         <= req.reg_sel;
      item.match_enable    <= req.match_enable;
      item.mask_enable     <= req.mask_enable;
      item.write_data      <= req.write_data;
      item.match_value     <= req.match_value;
      item.compare_mask    <= req.compare_mask;
      item.bus_read_data   <= req.bus_read_data;
      item.bus_error       <= req.bus_error;
    end
  end

endmodule

// File: hw/rtl/swdap_exec.sv
`timescale 1ns / 1ps
`include "swd_dp_mem_ap_transfer_core_defines.svh"

module swdap_exec
  import swdap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [31:0]  id_code,
  input  item_t        item,
  output result_t      result
);

  // dp / mem-ap state
  logic [31:0] control_status, control_status_next;
  logic [3:0]  ap_bank, ap_bank_next;
  logic [31:0] control_word, control_word_next;
  logic [31:0] transfer_address, transfer_address_next;
  logic [31:0] last_drw_read, last_drw_read_next;
  logic        packet_stopped, packet_stopped_next;

  logic [31:0] data;
  logic [31:0] cmp_mask;
  logic [2:0]  bsize;
  logic        fault;
  logic        mism;

  assign bsize    = size_bytes(control_word[1:0]);
  assign cmp_mask = item.mask_enable ? item.compare_mask : 32'hFFFF_FFFF;

  // execute one transfer
  always_comb begin
    control_status_next   = control_status;
    ap_bank_next          = ap_bank;
    control_word_next     = control_word;
    transfer_address_next = transfer_address;
    last_drw_read_next    = last_drw_read;
    packet_stopped_next   = packet_stopped;
    result                = '0;
    data                  = '0;
    fault                 = 1'b0;
    mism                  = 1'b0;

    if (item.action == ACTION_CONNECT) begin
      control_word_next   = CSW_RESET;
      packet_stopped_next = 1'b0;
    end else if (!item.first_of_packet && packet_stopped) begin
      result.skipped = 1'b1;
    end else begin
      if (!item.is_ap) begin
        // debug port registers
        if (item.is_read) begin
          case (item.reg_sel)
            DP_IDR:      data = id_code;
            DP_CTRL:     data = control_status;
            DP_READ_BUF: data = last_drw_read;
            default:     data = '0;
          endcase
        end else begin
          case (item.reg_sel)
            DP_CTRL:     control_status_next = item.write_data & CTRL_KEEP_MASK;
            DP_BANK_SEL: ap_bank_next = item.write_data[7:4];
            default:     ;
          endcase
        end
      end else if (ap_bank == 4'd0) begin
        // mem-ap bank 0
        case (item.reg_sel)
          AP_CSW: begin
            if (item.is_read) begin
              data = control_word;
            end else begin
              control_word_next = item.write_data;
            end
          end
          AP_TAR: begin
            if (item.is_read) begin
              data = transfer_address;
            end else begin
              transfer_address_next = item.write_data;
            end
          end
          AP_DRW: begin
            result.bus_valid   = 1'b1;
            result.bus_address = transfer_address;
            result.bus_size    = bsize;
            if (item.is_read) begin
              data               = item.bus_read_data & size_mask(bsize);
              last_drw_read_next = data;
            end else begin
              result.bus_write      = 1'b1;
              result.bus_write_data = item.write_data;
            end
            fault = item.bus_error;
            if (control_word[5:4] == INC_SINGLE) begin
              transfer_address_next = transfer_address + {29'd0, bsize};
            end
          end
          default: ;
        endcase
      end

      // value match on reads
      mism = item.is_read && item.match_enable && ((data & cmp_mask) != item.match_value);

      packet_stopped_next   = fault || mism;
      result.read_data      = item.is_read ? data : '0;
      result.has_read_data  = item.is_read;
      result.ack_fault      = fault;
      result.value_mismatch = mism;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_status   <= '0;
      ap_bank          <= '0;
      control_word     <= CSW_RESET;
      transfer_address <= '0;
      last_drw_read    <= '0;
      packet_stopped   <= 1'b0;
    end else if (fire) begin
      control_status   <= control_status_next;
      ap_bank          <= ap_bank_next;
      control_word     <= control_word_next;
      transfer_address <= transfer_address_next;
      last_drw_read    <= last_drw_read_next;
      packet_stopped   <= packet_stopped_next;
    end
  end

  // checks
  `SWDAP_ASSERT_NEXT(a_connect_clears, fire && item.action == ACTION_CONNECT,
    control_word == CSW_RESET && !packet_stopped, "connect did not restore csw and clear stop")
  `SWDAP_ASSERT_NEXT(a_fault_stops, fire && (result.ack_fault || result.value_mismatch),
    packet_stopped, "fault or mismatch did not stop packet")
  `SWDAP_ASSERT_NEXT(a_drw_read_kept, fire && result.bus_valid && !result.bus_write,
    last_drw_read == $past(result.read_data), "drw read not kept for rdbuff")
  `SWDAP_ASSERT_NOW(a_size_legal, fire && result.bus_valid,
    result.bus_size == SIZE_BYTE || result.bus_size == SIZE_HALF ||
    result.bus_size == SIZE_WORD, "illegal bus size")

endmodule

// File: hw/rtl/swdap_out_stage.sv
`timescale 1ns / 1ps

module swdap_out_stage
  import swdap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fill,
  input  result_t      result,
  output logic         advance,
  swdap_out_if.source  rsp
);

  logic    full;
  result_t held;

  // result register frees up when empty or when its beat is taken
  assign advance = !full || rsp.ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (advance) begin
      full <= fill;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && fill) begin
      held <= result;
    end
  end

  // drive the result channel
  assign rsp.valid          = full;
  assign rsp.read_data      = held.read_data;
  assign rsp.has_read_data  = held.has_read_data;
  assign rsp.ack_fault      = held.ack_fault;
  assign rsp.value_mismatch = held.value_mismatch;
  assign rsp.skipped        = held.skipped;
  assign rsp.bus_valid      = held.bus_valid;
  assign rsp.bus_write      = held.bus_write;
  assign rsp.bus_address    = held.bus_address;
  assign rsp.bus_size       = held.bus_size;
  assign rsp.bus_write_data = held.bus_write_data;

endmodule

// File: hw/rtl/swd_dp_mem_ap_transfer_core.sv
`timescale 1ns / 1ps
// a request is held in the input stage; its result is registered in the output stage
// throughput: one transfer per cycle unless rsp stalls; the dp/ap state updates as the result register loads
// the request side keeps taking beats while a result waits, until both stages are full
// reset (rst, synchronous, active high) empties both stages, clears ctrl/stat, bank,
// tar, rdbuff and the stop flag, sets csw to 32-bit and id code to its default

module swd_dp_mem_ap_transfer_core
  import swdap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  swdap_in_if.sink     req,
  swdap_out_if.source  rsp,
  swdap_cfg_if.sink    cfg
);

  logic    advance;
  logic    stage_valid;
  item_t   item;
  result_t result;
  logic    [31:0] id_code;

  // id code register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_code <= ID_CODE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      id_code <= cfg.data;
    end
  end

  swdap_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .valid   (stage_valid),
    .item    (item)
  );

  swdap_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .fire    (stage_valid && advance),
    .id_code (id_code),
    .item    (item),
    .result  (result)
  );

  swdap_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .fill    (stage_valid),
    .result  (result),
    .advance (advance),
    .rsp     (rsp)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import swdap_pkg::*;

  // ap register 2 has no function in bank 0
  localparam logic [1:0] AP_UNUSED = 2'd2;

  localparam int unsigned RANDOM_ITEMS     = 500;
  localparam int unsigned PHASE_COUNT      = 5;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned BURST_ITEMS      = 60;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  // expected transfer results, predicted from the dp/ap register state
  class transfer_scoreboard;
    logic [31:0] id_code;
    logic [31:0] ctrl_status;
    logic [3:0]  bank;
    logic [31:0] csw;
    logic [31:0] tar;
    logic [31:0] rdbuff;
    bit          stopped;
    result_t     expected_q[$];
    int unsigned error_count;

    function new();
      id_code     = ID_CODE_RESET;
      ctrl_status = '0;
      bank        = '0;
      csw         = CSW_RESET;
      tar         = '0;
      rdbuff      = '0;
      stopped     = 1'b0;
      error_count = 0;
    endfunction

    function void set_id_code(logic [31:0] value);
      id_code = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // one transfer applied to the register state
    function result_t predict_transfer(item_t it);
      result_t     r;
      logic [31:0] data;
      logic [31:0] cmp_mask;
      logic [2:0]  nbytes;
      r = '0;
      data = '0;
      if (it.action == ACTION_CONNECT) begin
        csw = CSW_RESET;
        stopped = 1'b0;
        return r;
      end
      if (it.first_of_packet) stopped = 1'b0;
      if (stopped) begin
        r.skipped = 1'b1;
        return r;
      end
      if (!it.is_ap) begin
        if (it.is_read) begin
          case (it.reg_sel)
            DP_IDR:      data = id_code;
            DP_CTRL:     data = ctrl_status;
            DP_READ_BUF: data = rdbuff;
            default:     data = '0;
          endcase
        end else begin
          case (it.reg_sel)
            DP_CTRL:     ctrl_status = it.write_data & CTRL_KEEP_MASK;
            DP_BANK_SEL: bank = it.write_data[7:4];
            default:     ;
          endcase
        end
      end else if (bank == 4'd0) begin
        case (it.reg_sel)
          AP_CSW: begin
            if (it.is_read) data = csw;
            else csw = it.write_data;
          end
          AP_TAR: begin
            if (it.is_read) data = tar;
            else tar = it.write_data;
          end
          AP_DRW: begin
            case (csw[1:0])
              2'd0:    nbytes = SIZE_BYTE;
              2'd1:    nbytes = SIZE_HALF;
              default: nbytes = SIZE_WORD;
            endcase
            r.bus_valid   = 1'b1;
            r.bus_size    = nbytes;
            r.bus_address = tar;
            if (it.is_read) begin
              if (nbytes == SIZE_BYTE) data = {24'd0, it.bus_read_data[7:0]};
              else if (nbytes == SIZE_HALF) data = {16'd0, it.bus_read_data[15:0]};
              else data = it.bus_read_data;
              rdbuff = data;
            end else begin
              r.bus_write      = 1'b1;
              r.bus_write_data = it.write_data;
            end
            r.ack_fault = it.bus_error;
            if (csw[5:4] == INC_SINGLE) tar = tar + 32'(nbytes);
          end
          default: ;
        endcase
      end
      // value match applies to reads only
      if (it.is_read && it.match_enable) begin
        cmp_mask = it.mask_enable ? it.compare_mask : 32'hFFFF_FFFF;
        r.value_mismatch = ((data & cmp_mask) != it.match_value);
      end
      if (r.ack_fault || r.value_mismatch) stopped = 1'b1;
      if (it.is_read) begin
        r.read_data     = data;
        r.has_read_data = 1'b1;
      end
      return r;
    endfunction

    function void note_request(item_t it);
      expected_q.push_back(predict_transfer(it));
    endfunction

    function void check_field(string field_name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, field_name, exp_v, got_v);
        error_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        error_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("read_data", exp_r.read_data, got.read_data);
      check_field("has_read_data", 32'(exp_r.has_read_data), 32'(got.has_read_data));
      check_field("ack_fault", 32'(exp_r.ack_fault), 32'(got.ack_fault));
      check_field("value_mismatch", 32'(exp_r.value_mismatch), 32'(got.value_mismatch));
      check_field("skipped", 32'(exp_r.skipped), 32'(got.skipped));
      check_field("bus_valid", 32'(exp_r.bus_valid), 32'(got.bus_valid));
      check_field("bus_write", 32'(exp_r.bus_write), 32'(got.bus_write));
      check_field("bus_address", exp_r.bus_address, got.bus_address);
      check_field("bus_size", 32'(exp_r.bus_size), 32'(got.bus_size));
      check_field("bus_write_data", exp_r.bus_write_data, got.bus_write_data);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  swdap_in_if  req_if ();
  swdap_out_if rsp_if ();
  swdap_cfg_if cfg_if ();

  transfer_scoreboard sb;
  item_t       seen_req;
  result_t     seen_rsp;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          no_gaps;
  bit          sink_eager;
  bit          sink_hold_req;

  swd_dp_mem_ap_transfer_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source),
    .cfg (cfg_if.sink)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_id_code(cfg_if.data);
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.read_data      = rsp_if.read_data;
        seen_rsp.has_read_data  = rsp_if.has_read_data;
        seen_rsp.ack_fault      = rsp_if.ack_fault;
        seen_rsp.value_mismatch = rsp_if.value_mismatch;
        seen_rsp.skipped        = rsp_if.skipped;
        seen_rsp.bus_valid      = rsp_if.bus_valid;
        seen_rsp.bus_write      = rsp_if.bus_write;
        seen_rsp.bus_address    = rsp_if.bus_address;
        seen_rsp.bus_size       = rsp_if.bus_size;
        seen_rsp.bus_write_data = rsp_if.bus_write_data;
        sb.check_result(seen_rsp);
      end
      if (req_if.valid && req_if.ready) begin
        seen_req.action          = req_if.action;
        seen_req.first_of_packet = req_if.first_of_packet;
        seen_req.is_read         = req_if.is_read;
        seen_req.is_ap           = req_if.is_ap;
        seen_req.reg_sel         = req_if.reg_sel;
        seen_req.match_enable    = req_if.match_enable;
        seen_req.mask_enable     = req_if.mask_enable;
        seen_req.write_data      = req_if.write_data;
        seen_req.match_value     = req_if.match_value;
        seen_req.compare_mask    = req_if.compare_mask;
        seen_req.bus_read_data   = req_if.bus_read_data;
        seen_req.bus_error       = req_if.bus_error;
        sb.note_request(seen_req);
      end
    end
  end

  // sender gap: mostly none or short, a few long
  function automatic int unsigned source_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned sink_run_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  // result ready pacing, with a long hold-off on request
  initial begin : sink_pace
    int unsigned run_len;
    bit          level;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        level = 1'b0;
        run_len = SINK_HOLD_CYCLES;
      end else if (sink_eager) begin
        level = 1'b1;
        run_len = 1;
      end else begin
        level = ($urandom_range(0, 3) != 0);
        run_len = sink_run_len();
      end
      rsp_if.ready <= level;
      repeat (run_len) @(posedge clk);
    end
  end

  // one request beat, offered and held until the core takes it
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = source_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.action          <= it.action;
    req_if.first_of_packet <= it.first_of_packet;
    req_if.is_read         <= it.is_read;
    req_if.is_ap           <= it.is_ap;
    req_if.reg_sel         <= it.reg_sel;
    req_if.match_enable    <= it.match_enable;
    req_if.mask_enable     <= it.mask_enable;
    req_if.write_data      <= it.write_data;
    req_if.match_value     <= it.match_value;
    req_if.compare_mask    <= it.compare_mask;
    req_if.bus_read_data   <= it.bus_read_data;
    req_if.bus_error       <= it.bus_error;
    req_if.valid           <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_id_code(logic [31:0] value);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic item_t xfer(bit rd, bit ap, logic [1:0] sel, logic [31:0] wd);
    item_t it;
    it = '0;
    it.action     = ACTION_XFER;
    it.is_read    = rd;
    it.is_ap      = ap;
    it.reg_sel    = sel;
    it.write_data = wd;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_csw();
    logic [31:0] w;
    w = rand_word();
    w[5:4] = ($urandom_range(0, 3) != 0) ? INC_SINGLE : 2'($urandom_range(0, 3));
    w[1:0] = 2'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic logic [31:0] rand_select(bit zero_bank);
    logic [31:0] w;
    w = rand_word();
    if (zero_bank) w[7:4] = 4'd0;
    return w;
  endfunction

  // well-formed transfer with random match and bus response
  function automatic item_t rand_xfer(bit rd, bit ap, logic [1:0] sel, logic [31:0] wd);
    item_t it;
    it = xfer(rd, ap, sel, wd);
    it.bus_read_data = rand_word();
    it.bus_error     = ($urandom_range(0, 19) == 0);
    it.mask_enable   = 1'($urandom_range(0, 1));
    it.compare_mask  = rand_word();
    it.match_value   = rand_word();
    it.match_enable  = ($urandom_range(0, 11) == 0);
    // a zero mask with zero value always matches
    if (it.match_enable && ($urandom_range(0, 1) != 0)) begin
      it.mask_enable  = 1'b1;
      it.compare_mask = '0;
      it.match_value  = '0;
    end
    return it;
  endfunction

  function automatic item_t rand_noise();
    item_t it;
    it.action          = 1'($urandom_range(0, 1));
    it.first_of_packet = 1'($urandom_range(0, 1));
    it.is_read         = 1'($urandom_range(0, 1));
    it.is_ap           = 1'($urandom_range(0, 1));
    it.reg_sel         = 2'($urandom_range(0, 3));
    it.match_enable    = 1'($urandom_range(0, 1));
    it.mask_enable     = 1'($urandom_range(0, 1));
    it.write_data      = rand_word();
    it.match_value     = rand_word();
    it.compare_mask    = rand_word();
    it.bus_read_data   = rand_word();
    it.bus_error       = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // one random packet: memory burst, register mix, other bank, connect or noise
  task automatic send_packet();
    int unsigned kind;
    int unsigned len;
    item_t       it;
    bit          rd;
    kind = $urandom_range(0, 19);
    len  = $urandom_range(1, 8);
    if (kind < 9) begin
      it = rand_xfer(1'b0, 1'b1, AP_CSW, rand_csw());
      it.first_of_packet = 1'b1;
      send_item(it);
      send_item(rand_xfer(1'b0, 1'b1, AP_TAR, rand_word()));
      repeat (len) send_item(rand_xfer(1'($urandom_range(0, 1)), 1'b1, AP_DRW, rand_word()));
      if ($urandom_range(0, 1) != 0) send_item(rand_xfer(1'b1, 1'b0, DP_READ_BUF, rand_word()));
    end else if (kind < 15) begin
      for (int k = 0; k < len; k++) begin
        rd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
          it = rand_xfer(rd, 1'b0, DP_BANK_SEL, rand_select($urandom_range(0, 3) != 0));
        end else begin
          it = rand_xfer(rd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_word());
          if (it.is_ap && !rd && it.reg_sel == AP_CSW) it.write_data = rand_csw();
        end
        it.first_of_packet = (k == 0);
        send_item(it);
      end
    end else if (kind < 17) begin
      it = rand_xfer(1'b0, 1'b0, DP_BANK_SEL, rand_select(1'b0));
      if (it.write_data[7:4] == 4'd0) it.write_data[7:4] = 4'($urandom_range(1, 15));
      it.first_of_packet = 1'b1;
      send_item(it);
      repeat (len) send_item(rand_xfer(1'($urandom_range(0, 1)), 1'b1,
                                       2'($urandom_range(0, 3)), rand_word()));
      send_item(rand_xfer(1'b0, 1'b0, DP_BANK_SEL, rand_select(1'b1)));
    end else if (kind < 18) begin
      it = rand_noise();
      it.action = ACTION_CONNECT;
      send_item(it);
      send_item(rand_xfer(1'b1, 1'b1, AP_CSW, rand_word()));
    end else begin
      repeat (len) send_item(rand_noise());
    end
  endtask

  // memory writes offered back to back while the result side holds off
  task automatic pressure_burst();
    item_t it;
    sink_hold_req = 1'b1;
    no_gaps = 1'b1;
    it = xfer(1'b0, 1'b1, AP_CSW, 32'h0000_0012);
    it.first_of_packet = 1'b1;
    send_item(it);
    repeat (BURST_ITEMS) send_item(xfer(1'b0, 1'b1, AP_DRW, $urandom));
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    item_t       it;
    logic [31:0] phase_id;
    int unsigned target;
    sb = new();
    req_if.valid           <= 1'b0;
    req_if.action          <= ACTION_XFER;
    req_if.first_of_packet <= 1'b0;
    req_if.is_read         <= 1'b0;
    req_if.is_ap           <= 1'b0;
    req_if.reg_sel         <= DP_IDR;
    req_if.match_enable    <= 1'b0;
    req_if.mask_enable     <= 1'b0;
    req_if.write_data      <= '0;
    req_if.match_value     <= '0;
    req_if.compare_mask    <= '0;
    req_if.bus_read_data   <= '0;
    req_if.bus_error       <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    rst                    <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // dp registers, ignored writes, unused select
    send_item(xfer(1'b1, 1'b0, DP_IDR, '0));
    send_item(xfer(1'b0, 1'b0, DP_CTRL, 32'hFFFF_FFFF));
    send_item(xfer(1'b1, 1'b0, DP_CTRL, '0));
    send_item(xfer(1'b0, 1'b0, DP_CTRL, '0));
    send_item(xfer(1'b1, 1'b0, DP_BANK_SEL, '0));
    send_item(xfer(1'b0, 1'b0, DP_IDR, 32'hFFFF_FFFF));
    send_item(xfer(1'b0, 1'b0, DP_READ_BUF, 32'hFFFF_FFFF));

    // csw/tar, word write with tar wrap
    send_item(xfer(1'b1, 1'b1, AP_CSW, '0));
    send_item(xfer(1'b0, 1'b1, AP_CSW, 32'h0000_0012));
    send_item(xfer(1'b0, 1'b1, AP_TAR, 32'hFFFF_FFFC));
    send_item(xfer(1'b0, 1'b1, AP_DRW, 32'hFFFF_FFFF));
    send_item(xfer(1'b1, 1'b1, AP_TAR, '0));

    // byte read, then readback via rdbuff
    send_item(xfer(1'b0, 1'b1, AP_CSW, 32'h0000_0010));
    it = xfer(1'b1, 1'b1, AP_DRW, '0);
    it.bus_read_data = 32'hFFFF_FFFF;
    send_item(it);
    send_item(xfer(1'b1, 1'b0, DP_READ_BUF, '0));

    // faulting halfword read stops the packet
    send_item(xfer(1'b0, 1'b1, AP_CSW, 32'hFFFF_FF11));
    it = xfer(1'b1, 1'b1, AP_DRW, '0);
    it.bus_read_data = 32'hA5A5_5A5A;
    it.bus_error = 1'b1;
    send_item(it);
    send_item(xfer(1'b1, 1'b0, DP_IDR, '0));

    // size code 3 with a non-single increment mode
    it = xfer(1'b0, 1'b1, AP_CSW, 32'h0000_0023);
    it.first_of_packet = 1'b1;
    send_item(it);
    send_item(xfer(1'b0, 1'b1, AP_DRW, 32'h1234_5678));
    send_item(xfer(1'b1, 1'b1, AP_UNUSED, '0));
    send_item(xfer(1'b0, 1'b1, AP_UNUSED, 32'hFFFF_FFFF));

    // nonzero bank reads zero and ignores writes
    send_item(xfer(1'b0, 1'b0, DP_BANK_SEL, 32'h0000_00F0));
    send_item(xfer(1'b1, 1'b1, AP_CSW, '0));
    send_item(xfer(1'b0, 1'b1, AP_TAR, 32'hFFFF_FFFF));
    send_item(xfer(1'b0, 1'b0, DP_BANK_SEL, 32'hFFFF_FF0F));

    // value match: mismatch, masked match, ignored on write
    it = xfer(1'b1, 1'b0, DP_IDR, '0);
    it.match_enable = 1'b1;
    send_item(it);
    it = xfer(1'b1, 1'b0, DP_IDR, '0);
    it.first_of_packet = 1'b1;
    it.match_enable = 1'b1;
    it.mask_enable = 1'b1;
    it.compare_mask = 32'hFFFF_0000;
    it.match_value = ID_CODE_RESET & 32'hFFFF_0000;
    send_item(it);
    it = xfer(1'b0, 1'b0, DP_CTRL, 32'hFFFF_FFFF);
    it.match_enable = 1'b1;
    send_item(it);

    // connect resets csw and clears the stop
    it = rand_noise();
    it.action = ACTION_CONNECT;
    send_item(it);
    send_item(xfer(1'b1, 1'b1, AP_CSW, '0));
    drain();

    // random phases, each with its own id code
    target = items_sent;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       phase_id = 32'h0000_0000;
        1:       phase_id = 32'hFFFF_FFFF;
        4:       phase_id = ID_CODE_RESET;
        default: phase_id = $urandom;
      endcase
      write_id_code(phase_id);
      sink_eager = (ph == 3);
      no_gaps = (ph == 3);
      if (ph == 2) pressure_burst();
      target = target + RANDOM_ITEMS / PHASE_COUNT;
      while (items_sent < target) send_packet();
      no_gaps = 1'b0;
      sink_eager = 1'b0;
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/swdap_pkg.sv
hw/rtl/swdap_if.sv
hw/rtl/swdap_in_stage.sv
hw/rtl/swdap_exec.sv
hw/rtl/swdap_out_stage.sv
hw/rtl/swd_dp_mem_ap_transfer_core.sv
test/tb_top.sv
